FILE: rtl/rc_pwm_pulse_width_decoder_unit_assert.svh
// Assertion macros for the RC PWM pulse width decoder.
// Uses no other file; the including module must provide clk and rst_n.
`ifndef RC_PWM_PULSE_WIDTH_DECODER_UNIT_ASSERT_SVH
`define RC_PWM_PULSE_WIDTH_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define RPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, during reset too.
`define RPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPD_ASSERT(lbl, prop, msg)
`define RPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/rpd_pkg.sv
// Shared types and constants for the RC PWM pulse width decoder.
// No dependencies.
`timescale 1ns / 1ps

package rpd_pkg;

    localparam int RPD_NUM_CHANNELS = 8;
    localparam int RPD_AVG_SAMPLES  = 8;

    localparam int CH_W      = 3;   // channel_index and channel_echo
    localparam int LEVELS_W  = 8;
    localparam int WIDTH_W   = 16;  // stored pulse widths and results
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    localparam logic [WIDTH_W-1:0]  MIN_WIDTH_RESET = 16'd750;
    localparam logic [WIDTH_W-1:0]  MAX_WIDTH_RESET = 16'd2250;
    localparam logic [LEVELS_W-1:0] ENABLE_RESET    = 8'hFF;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_VALID_WIDTH = 2'd0,
        CFG_MAX_VALID_WIDTH = 2'd1,
        CFG_CHANNEL_ENABLE  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAPTURE,
        ST_READ,
        ST_CHECK,
        ST_DIVIDE,
        ST_OUTPUT
    } rpd_state_t;

endpackage

FILE: rtl/rpd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/rc_pwm_pulse_width_decoder_unit.sv
// Top level of the RC PWM pulse width decoder: sequencer, shared subtractor, ring RAM.
// Depends on rpd_pkg, rpd_ram and rc_pwm_pulse_width_decoder_unit_assert.svh.
`timescale 1ns / 1ps
`include "rc_pwm_pulse_width_decoder_unit_assert.svh"

// Decodes up to eight RC PWM channels. A sample item (tuser 0) carries the pin levels
// and a microsecond timestamp; enabled channels record a start time on a rising edge and
// push the high time (16-bit wrap) into a per-channel ring of AVG_SAMPLES widths on a
// falling edge. A query item (tuser 1) returns the truncated mean of the ring entries
// inside [min_valid_width, max_valid_width], or 0 if fewer than AVG_SAMPLES/2 are
// valid or the channel is not built. One item is in flight at a time and s_axis_tready
// is low while it is worked on. A sample passes one channel per cycle through the shared
// subtractor and the single ring write port. A query walks the ring through its
// registered read port, then runs restoring division on the same subtractor, then hands
// over the result, which m_axis_tready may stall, and passes through the idle state
// before the next item is taken. Ring entries never written read as zero through a
// per-channel fill count, so no clearing pass is needed after reset.
// Configuration writes are always accepted.
module rc_pwm_pulse_width_decoder_unit
    import rpd_pkg::*;
#(
    parameter int NUM_CHANNELS = RPD_NUM_CHANNELS,
    parameter int AVG_SAMPLES  = RPD_AVG_SAMPLES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] pin_levels, [39:8] time_us, [42:40] channel_index, [47:43] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] channel_value, [18:16] channel_echo, [23:19] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data
);

    localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int POS_W     = $clog2(AVG_SAMPLES);
    localparam int FILL_W    = $clog2(AVG_SAMPLES + 1);
    localparam int STEP_W    = $clog2(AVG_SAMPLES + 1);
    localparam int GOOD_W    = $clog2(AVG_SAMPLES + 1);
    localparam int SUM_W     = WIDTH_W + $clog2(AVG_SAMPLES);
    localparam int ALU_W     = SUM_W + 1;
    localparam int DIV_CNT_W = $clog2(SUM_W);
    localparam int RAM_DEPTH = NUM_CHANNELS * AVG_SAMPLES;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    // control state
    rpd_state_t          state_reg, state_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [LEVELS_W-1:0] prev_reg, prev_next;
    logic [WIDTH_W-1:0]  start_reg [NUM_CHANNELS];
    logic [WIDTH_W-1:0]  start_next [NUM_CHANNELS];
    logic [POS_W-1:0]    pos_reg [NUM_CHANNELS];
    logic [POS_W-1:0]    pos_next [NUM_CHANNELS];
    logic [FILL_W-1:0]   fill_reg [NUM_CHANNELS];
    logic [FILL_W-1:0]   fill_next [NUM_CHANNELS];
    logic [WIDTH_W-1:0]  min_reg;
    logic [WIDTH_W-1:0]  max_reg;
    logic [LEVELS_W-1:0] mask_reg;

    // payload
    logic [LEVELS_W-1:0] pin_reg, pin_next;
    logic [WIDTH_W-1:0]  time_reg, time_next;
    logic                ok_reg, ok_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [GOOD_W-1:0]   good_reg, good_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [GOOD_W-1:0]   rem_reg, rem_next;
    logic [WIDTH_W-1:0]  val_reg, val_next;

    // shared subtractor
    logic [ALU_W-1:0]    alu_a, alu_b, alu_diff;
    logic                alu_ge;
    logic [GOOD_W:0]     div_trial;

    logic [CH_IDX_W-1:0] ch_idx;
    logic [POS_W-1:0]    slot;
    logic [ADDR_W-1:0]   ram_addr;
    logic                ram_we, ram_re;
    logic [WIDTH_W-1:0]  ram_rdata;
    logic [WIDTH_W-1:0]  ring_val;

    assign ch_idx    = ch_reg[CH_IDX_W-1:0];
    assign slot      = (state_reg == ST_CAPTURE) ? pos_reg[ch_idx] : step_reg[POS_W-1:0];
    assign ram_addr  = ADDR_W'(ADDR_W'(ch_idx) * ADDR_W'(AVG_SAMPLES)) + ADDR_W'(slot);
    assign div_trial = {rem_reg, quo_reg[SUM_W-1]};
    assign ring_val  = ok_reg ? ram_rdata : '0;

    always_comb
    begin
        if (state_reg == ST_CAPTURE)
        begin
            alu_a = ALU_W'(time_reg);
            alu_b = ALU_W'(start_reg[ch_idx]);
        end
        else
        begin
            alu_a = ALU_W'(div_trial);
            alu_b = ALU_W'(good_reg);
        end
        alu_diff = alu_a - alu_b;
        alu_ge   = !alu_diff[ALU_W-1];
    end

    rpd_ram #(
        .WIDTH (WIDTH_W),
        .DEPTH (RAM_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_addr),
        .wr_data (alu_diff[WIDTH_W-1:0]),
        .rd_en   (ram_re),
        .rd_addr (ram_addr),
        .rd_data (ram_rdata)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUTPUT);
    assign m_axis_tdata  = {{(OUT_DATA_W - CH_W - WIDTH_W){1'b0}}, ch_reg, val_reg};

    always_comb
    begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        step_next    = step_reg;
        div_cnt_next = div_cnt_reg;
        prev_next    = prev_reg;
        start_next   = start_reg;
        pos_next     = pos_reg;
        fill_next    = fill_reg;
        pin_next     = pin_reg;
        time_next    = time_reg;
        ok_next      = ok_reg;
        sum_next     = sum_reg;
        good_next    = good_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        val_next     = val_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    pin_next  = s_axis_tdata[7:0];
                    time_next = s_axis_tdata[23:8];
                    sum_next  = '0;
                    good_next = '0;
                    step_next = '0;
                    if (s_axis_tuser == MODE_SAMPLE)
                    begin
                        ch_next    = '0;
                        state_next = ST_CAPTURE;
                    end
                    else
                    begin
                        ch_next = s_axis_tdata[42:40];
                        if ({1'b0, s_axis_tdata[42:40]} >= (CH_W + 1)'(NUM_CHANNELS))
                        begin
                            val_next   = '0;
                            state_next = ST_OUTPUT;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
            end

            ST_CAPTURE:
            begin
                // one channel a cycle: start time on a rise, ring write on a fall
                if (mask_reg[ch_reg] && (pin_reg[ch_reg] ^ prev_reg[ch_reg]))
                begin
                    if (pin_reg[ch_reg])
                    begin
                        start_next[ch_idx] = time_reg;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        if (pos_reg[ch_idx] == POS_W'(AVG_SAMPLES - 1))
                        begin
                            pos_next[ch_idx] = '0;
                        end
                        else
                        begin
                            pos_next[ch_idx] = pos_reg[ch_idx] + 1'b1;
                        end
                        if (fill_reg[ch_idx] != FILL_W'(AVG_SAMPLES))
                        begin
                            fill_next[ch_idx] = fill_reg[ch_idx] + 1'b1;
                        end
                    end
                end
                if ({1'b0, ch_reg} == (CH_W + 1)'(NUM_CHANNELS - 1))
                begin
                    prev_next  = pin_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end

            ST_READ:
            begin
                // issue slot k while accumulating slot k-1
                if (step_reg != STEP_W'(AVG_SAMPLES))
                begin
                    ram_re  = 1'b1;
                    ok_next = FILL_W'(slot) < fill_reg[ch_idx];
                end
                if (step_reg != '0)
                begin
                    if ((ring_val >= min_reg) && (ring_val <= max_reg))
                    begin
                        sum_next  = sum_reg + SUM_W'(ring_val);
                        good_next = good_reg + 1'b1;
                    end
                end
                if (step_reg == STEP_W'(AVG_SAMPLES))
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end

            ST_CHECK:
            begin
                if ((good_reg < GOOD_W'(AVG_SAMPLES / 2)) || (good_reg == '0))
                begin
                    val_next   = '0;
                    state_next = ST_OUTPUT;
                end
                else
                begin
                    quo_next     = sum_reg;
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIVIDE;
                end
            end

            ST_DIVIDE:
            begin
                // restoring division, one quotient bit a cycle
                quo_next = {quo_reg[SUM_W-2:0], alu_ge};
                rem_next = alu_ge ? alu_diff[GOOD_W-1:0] : div_trial[GOOD_W-1:0];
                if (div_cnt_reg == DIV_CNT_W'(SUM_W - 1))
                begin
                    val_next   = quo_next[WIDTH_W-1:0];
                    state_next = ST_OUTPUT;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end

            ST_OUTPUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ch_reg      <= '0;
            step_reg    <= '0;
            div_cnt_reg <= '0;
            prev_reg    <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                start_reg[i] <= '0;
                pos_reg[i]   <= '0;
                fill_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            step_reg    <= step_next;
            div_cnt_reg <= div_cnt_next;
            prev_reg    <= prev_next;
            start_reg   <= start_next;
            pos_reg     <= pos_next;
            fill_reg    <= fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= MIN_WIDTH_RESET;
            max_reg  <= MAX_WIDTH_RESET;
            mask_reg <= ENABLE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_VALID_WIDTH: min_reg  <= cfg_data;
                CFG_MAX_VALID_WIDTH: max_reg  <= cfg_data;
                CFG_CHANNEL_ENABLE:  mask_reg <= cfg_data[LEVELS_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        pin_reg  <= pin_next;
        time_reg <= time_next;
        ok_reg   <= ok_next;
        sum_reg  <= sum_next;
        good_reg <= good_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        val_reg  <= val_next;
    end

    `RPD_ASSERT(a_no_accept_while_result, !(s_axis_tready && m_axis_tvalid), "input accepted while a result is pending")
    `RPD_ASSERT(a_sample_to_capture, (s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_SAMPLE)) |=> (state_reg == ST_CAPTURE), "sample item did not start edge capture")
    `RPD_ASSERT(a_rem_below_divisor, (state_reg == ST_DIVIDE) |-> (rem_reg < good_reg), "division remainder not below divisor")
    `RPD_ASSERT(a_absent_channel_zero, (m_axis_tvalid && ({1'b0, m_axis_tdata[18:16]} >= (CH_W + 1)'(NUM_CHANNELS))) |-> (m_axis_tdata[15:0] == '0), "absent channel reported non-zero")

endmodule
